// File: hdl/evd_pkg.sv
// shared types, widths and constants of the ema option value decider
package evd_pkg;

    // default table depth
    localparam int TABLE_ENTRIES_DEF = 256;

    // field and register widths
    localparam int VALUE_W    = 24;
    localparam int DECAY_W    = 17;
    localparam int PERIOD_W   = 16;
    localparam int STEP_W     = 32;
    localparam int COUNT_W    = 9;
    localparam int INDEX_W    = 8;
    localparam int DEC_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int FRAC_W     = 16;
    // signed difference times zero-extended decay
    localparam int PROD_W     = (VALUE_W + 1) + (DECAY_W + 1);

    // register reset values
    localparam logic [DECAY_W-1:0]         DECAY_ONE  = 17'd65536;
    localparam logic [DECAY_W-1:0]         DECAY_RST  = 17'd58982;
    localparam logic signed [VALUE_W-1:0]  MARGIN_RST = 24'sd0;
    localparam logic [PERIOD_W-1:0]        PERIOD_RST = 16'd16;

    // decision codes
    typedef enum logic [DEC_W-1:0] {
        DEC_EXPLORE = 2'd0,
        DEC_CHOOSE  = 2'd1,
        DEC_AVOID   = 2'd2
    } t_decision;

    // input word kinds
    typedef enum logic {
        KIND_DECIDE = 1'b0,
        KIND_UPDATE = 1'b1
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY  = 2'd0,
        CFG_MARGIN = 2'd1,
        CFG_PERIOD = 2'd2
    } t_cfg_idx;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD_MUL,
        ST_UPD_WR,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// File: hdl/evd_in_if.sv
// input channel: decide requests and value updates
interface evd_in_if;
    import evd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [COUNT_W-1:0]         option_count;
    logic [INDEX_W-1:0]         option_index;
    logic signed [VALUE_W-1:0]  reward_value;

    modport source (
        output valid, kind, option_count, option_index, reward_value,
        input  ready
    );

    modport sink (
        input  valid, kind, option_count, option_index, reward_value,
        output ready
    );
endinterface

// File: hdl/evd_out_if.sv
// output channel: decisions
interface evd_out_if;
    import evd_pkg::*;

    logic               valid;
    logic               ready;
    logic [DEC_W-1:0]   decision;

    modport source (
        output valid, decision,
        input  ready
    );

    modport sink (
        input  valid, decision,
        output ready
    );
endinterface

// File: hdl/evd_ram.sv
// generic single write port ram with registered read
module evd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/evd_rem.sv
// bit-serial remainder of the step count by the explore period
module evd_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [evd_pkg::STEP_W-1:0]    i_dividend,
    input  logic [evd_pkg::PERIOD_W-1:0]  i_divisor,
    output logic                          o_busy,
    output logic [evd_pkg::PERIOD_W-1:0]  o_rem
);
    import evd_pkg::*;

    localparam int CNT_W = $clog2(STEP_W + 1);

    logic [CNT_W-1:0]    r_cnt;
    logic [STEP_W-1:0]   r_dvd;
    logic [PERIOD_W-1:0] r_div;
    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W:0]   w_trial;
    logic [PERIOD_W:0]   w_diff;

    // shift in one dividend bit and try a subtract
    assign w_trial = {r_rem, r_dvd[STEP_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(STEP_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // restoring remainder datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[STEP_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= w_diff[PERIOD_W-1:0];
            end else begin
                r_rem <= w_trial[PERIOD_W-1:0];
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;
endmodule

// File: hdl/ema_option_value_decider.sv
// EMA option value decider: a table of signed Q8.16 value estimates kept in a
// one-read one-write RAM. After reset the table is cleared by a sweep over all
// TABLE_ENTRIES entries during which no word is accepted (configuration writes
// are taken). An update word reads the entry, multiplies the decay by the
// difference of old value and reward, and writes back; an unknown (zero) entry
// is written with the reward without the multiply step. A decide word with a
// nonzero count scans limit entries, limit being option_count capped at
// TABLE_ENTRIES: the RAM read port scans one entry per cycle while a 32-step
// serial unit forms the step count modulo the explore period. A decide word
// with a zero count is taken and gives no decision. A finished decision waits
// in an output register, and the next word is accepted while it is still
// pending; a following decision holds in its finish state until that register
// is free.
module ema_option_value_decider #(
    parameter int TABLE_ENTRIES = evd_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    evd_in_if.sink                          i_in,
    evd_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [evd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [evd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import evd_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

    t_state                     r_state;
    t_state                     n_state;
    logic [AW-1:0]              r_clr_addr;
    logic [STEP_W-1:0]          r_step;
    logic [DECAY_W-1:0]         r_decay;
    logic signed [VALUE_W-1:0]  r_margin;
    logic [PERIOD_W-1:0]        r_period;
    logic [AW-1:0]              r_idx;
    logic signed [VALUE_W-1:0]  r_reward;
    logic signed [PROD_W-1:0]   r_prod;
    logic [AW-1:0]              r_scan_addr;
    logic [COUNT_W-1:0]         r_left;
    logic                       r_cmp_valid;
    logic                       r_known;
    logic signed [VALUE_W-1:0]  r_best;
    logic                       r_s_nz;
    logic                       r_out_valid;
    t_decision                  r_out_dec;

    logic                       w_accept;
    logic                       w_idx_ok;
    logic [COUNT_W-1:0]         w_limit;
    logic                       w_ram_we;
    logic [AW-1:0]              w_ram_waddr;
    logic [VALUE_W-1:0]         w_ram_wdata;
    logic [AW-1:0]              w_ram_raddr;
    logic [VALUE_W-1:0]         w_ram_rdata;
    logic signed [VALUE_W-1:0]  w_old;
    logic                       w_rem_start;
    logic                       w_rem_busy;
    logic [PERIOD_W-1:0]        w_rem;
    logic [DECAY_W-1:0]         w_decay;
    logic signed [VALUE_W:0]    w_diff;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [PROD_W-1:0]   w_sum;
    logic                       w_forced;
    logic                       w_out_load;
    t_decision                  w_dec;

    // value table
    evd_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // step count modulo explore period
    evd_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rem_start),
        .i_dividend (r_step),
        .i_divisor  (r_period),
        .o_busy     (w_rem_busy),
        .o_rem      (w_rem)
    );

    // input word decode
    assign w_accept = i_in.valid && i_in.ready;
    assign w_idx_ok = 32'(i_in.option_index) < 32'(TABLE_ENTRIES);
    assign w_limit  = (32'(i_in.option_count) >= 32'(TABLE_ENTRIES))
                    ? COUNT_W'(TABLE_ENTRIES) : i_in.option_count;

    // update arithmetic: reward + floor(decay * (old - reward) / 2^16)
    assign w_old   = $signed(w_ram_rdata);
    assign w_decay = (r_decay > DECAY_ONE) ? DECAY_ONE : r_decay;
    assign w_diff  = $signed({w_old[VALUE_W-1], w_old})
                   - $signed({r_reward[VALUE_W-1], r_reward});
    assign w_prod  = w_diff * $signed({1'b0, w_decay});
    assign w_sum   = $signed({{(PROD_W-VALUE_W){r_reward[VALUE_W-1]}}, r_reward})
                   + (r_prod >>> FRAC_W);

    // final decision
    assign w_forced   = r_s_nz && (r_period != '0) && (w_rem == '0);
    assign w_out_load = (r_state == ST_FINISH) && (!r_out_valid || o_out.ready);

    always_comb begin
        priority if (w_forced) begin
            w_dec = DEC_EXPLORE;
        end else if (r_known && (r_best < r_margin)) begin
            w_dec = DEC_AVOID;
        end else if (r_known) begin
            w_dec = DEC_CHOOSE;
        end else begin
            w_dec = DEC_EXPLORE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.kind == KIND_UPDATE) begin
                        if (w_idx_ok) begin
                            n_state = ST_UPD_MUL;
                        end
                    end else if (i_in.option_count != '0) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_UPD_MUL: begin
                n_state = (w_old == '0) ? ST_IDLE : ST_UPD_WR;
            end
            ST_UPD_WR: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if ((r_left == '0) && !r_cmp_valid && !w_rem_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state outputs: ram ports, remainder start, input ready
    always_comb begin
        i_in.ready  = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_idx;
        w_ram_wdata = r_reward;
        w_ram_raddr = r_scan_addr;
        w_rem_start = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            ST_IDLE: begin
                i_in.ready  = 1'b1;
                w_ram_raddr = AW'(32'(i_in.option_index));
                w_rem_start = i_in.valid && (i_in.kind == KIND_DECIDE)
                            && (i_in.option_count != '0);
            end
            ST_UPD_MUL: begin
                w_ram_we = (w_old == '0);
            end
            ST_UPD_WR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = w_sum[VALUE_W-1:0];
            end
            ST_SCAN, ST_FINISH: begin
                w_ram_raddr = r_scan_addr;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_step      <= '0;
            r_decay     <= DECAY_RST;
            r_margin    <= MARGIN_RST;
            r_period    <= PERIOD_RST;
            r_left      <= '0;
            r_cmp_valid <= 1'b0;
            r_known     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // clearing sweep
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            // configuration writes
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_DECAY:  r_decay  <= i_cfg_data[DECAY_W-1:0];
                    CFG_MARGIN: r_margin <= $signed(i_cfg_data[VALUE_W-1:0]);
                    CFG_PERIOD: r_period <= i_cfg_data[PERIOD_W-1:0];
                    default: begin
                        r_period <= r_period;
                    end
                endcase
            end

            // decide start and scan
            if (w_rem_start) begin
                r_step      <= r_step + 1'b1;
                r_left      <= w_limit;
                r_cmp_valid <= 1'b0;
                r_known     <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_cmp_valid <= (r_left != '0);
                if (r_left != '0) begin
                    r_left <= r_left - 1'b1;
                end
                if (r_cmp_valid && (w_old != '0)) begin
                    r_known <= 1'b1;
                end
            end

            // output word register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx    <= AW'(32'(i_in.option_index));
            r_reward <= i_in.reward_value;
        end
        if (w_rem_start) begin
            r_s_nz      <= (r_step != '0);
            r_scan_addr <= '0;
        end else if ((r_state == ST_SCAN) && (r_left != '0)) begin
            r_scan_addr <= r_scan_addr + 1'b1;
        end
        if ((r_state == ST_SCAN) && r_cmp_valid && (w_old != '0)
            && (!r_known || (w_old > r_best))) begin
            r_best <= w_old;
        end
        if (r_state == ST_UPD_MUL) begin
            r_prod <= w_prod;
        end
        if (w_out_load) begin
            r_out_dec <= w_dec;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.decision = r_out_dec;

    // step counter moves by one for each decide word with a nonzero count
    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.kind == KIND_DECIDE) && (i_in.option_count != '0))
        |=> (r_step == $past(r_step) + 1'b1))
        else $error("step counter did not advance by one");

    // a decision is only formed after the scan and the remainder are done
    a_finish_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> (!w_rem_busy && (r_left == '0) && !r_cmp_valid))
        else $error("decision formed before scan or remainder finished");

    // no word is taken while a table entry is being rewritten
    a_rmw_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.kind == KIND_UPDATE) && w_idx_ok) |=> !i_in.ready)
        else $error("word accepted during read-modify-write");

    // the write-back only follows the multiply step
    a_wr_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD_WR) |-> ($past(r_state) == ST_UPD_MUL))
        else $error("write-back without a preceding multiply");

endmodule

// File: tb/sv/tb_top.sv
// testbench for the ema option value decider: directed corners, then random words
`timescale 1ns / 100ps

module tb_top;
    import evd_pkg::*;

    localparam int TBL_ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int SETTLE_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int WORDS_PER_PASS = 180;
    localparam int MAX_PRINTS     = 50;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = -(2 ** (VALUE_W - 1));
    localparam logic signed [VALUE_W-1:0] VAL_MAX = (2 ** (VALUE_W - 1)) - 1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    evd_in_if  in_ch ();
    evd_out_if out_ch ();

    ema_option_value_decider #(
        .TABLE_ENTRIES (TBL_ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state: value estimates, decide step count and register shadows
    logic signed [VALUE_W-1:0] value_est [TBL_ENTRIES];
    logic [STEP_W-1:0]         decide_steps;
    logic [DECAY_W-1:0]        decay_reg;
    logic signed [VALUE_W-1:0] margin_reg;
    logic [PERIOD_W-1:0]       period_reg;

    t_decision expected_decisions [$];
    t_decision want_decision;
    int        mismatch_count;
    int        send_idle_pct;
    int        sink_stall_pct;
    int        idle_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // mismatch report, printing capped but every failure counted
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // predict the effect of one accepted word on the table and the decisions
    function automatic void predict_word(input t_kind kind,
                                         input logic [COUNT_W-1:0] count,
                                         input logic [INDEX_W-1:0] index,
                                         input logic signed [VALUE_W-1:0] reward);
        longint                    wt;
        longint                    mix;
        int                        lim;
        bit                        found;
        logic signed [VALUE_W-1:0] best;
        logic [STEP_W-1:0]         step;
        if (kind == KIND_UPDATE) begin
            if (value_est[index] == '0) begin
                value_est[index] = reward;
            end else begin
                // decay above one saturates at one
                wt = longint'(decay_reg);
                if (wt > longint'(DECAY_ONE)) begin
                    wt = longint'(DECAY_ONE);
                end
                mix = wt * longint'(value_est[index])
                    + (longint'(DECAY_ONE) - wt) * longint'(reward);
                value_est[index] = VALUE_W'(mix >>> FRAC_W);
            end
        end else if (count != '0) begin
            step         = decide_steps;
            decide_steps = decide_steps + 1'b1;
            if (step != '0 && period_reg != '0 && (step % period_reg) == '0) begin
                expected_decisions.push_back(DEC_EXPLORE);
            end else begin
                // scan is capped at the table size
                lim   = (count < TBL_ENTRIES) ? int'(count) : TBL_ENTRIES;
                found = 1'b0;
                best  = '0;
                for (int i = 0; i < lim; i++) begin
                    if (value_est[i] != '0) begin
                        if (!found || value_est[i] > best) begin
                            best = value_est[i];
                        end
                        found = 1'b1;
                    end
                end
                if (found && best < margin_reg) begin
                    expected_decisions.push_back(DEC_AVOID);
                end else if (found) begin
                    expected_decisions.push_back(DEC_CHOOSE);
                end else begin
                    expected_decisions.push_back(DEC_EXPLORE);
                end
            end
        end
    endfunction

    // send one word with a random idle gap ahead of it
    task automatic send_word(input t_kind kind,
                             input logic [COUNT_W-1:0] count,
                             input logic [INDEX_W-1:0] index,
                             input logic signed [VALUE_W-1:0] reward);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.option_count <= count;
        in_ch.option_index <= index;
        in_ch.reward_value <= reward;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        predict_word(kind, count, index, reward);
    endtask

    // wait for every decision, then let a word with no result drain
    task automatic settle_block();
        in_ch.valid <= 1'b0;
        while (expected_decisions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all three registers, block idle
    task automatic set_config(input logic [DECAY_W-1:0] decay,
                              input logic signed [VALUE_W-1:0] margin,
                              input logic [PERIOD_W-1:0] period);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DECAY;
        i_cfg_data <= CFG_DATA_W'(decay);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MARGIN;
        i_cfg_data <= CFG_DATA_W'(margin);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PERIOD;
        i_cfg_data <= CFG_DATA_W'(period);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        decay_reg  = decay;
        margin_reg = margin;
        period_reg = period;
    endtask

    // reset values: empty table, extremes of reward, index and count
    task automatic test_reset_table();
        send_word(KIND_DECIDE, 9'd1, 8'd0, '0);
        send_word(KIND_DECIDE, 9'd0, 8'd255, VAL_MAX);
        send_word(KIND_UPDATE, 9'd511, 8'd0, VAL_MIN);
        send_word(KIND_DECIDE, 9'd1, 8'd0, '0);
        send_word(KIND_UPDATE, 9'd0, 8'd255, VAL_MAX);
        send_word(KIND_DECIDE, 9'd256, 8'd0, '0);
        send_word(KIND_DECIDE, 9'd511, 8'd128, VAL_MIN);
        send_word(KIND_UPDATE, 9'd0, 8'd0, VAL_MAX);
        send_word(KIND_UPDATE, 9'd0, 8'd128, 24'sd1);
        send_word(KIND_DECIDE, 9'd255, 8'd0, '0);
        settle_block();
    endtask

    // decay above one, forced explore, zero period, entry decaying to unknown
    task automatic test_register_corners();
        set_config(DECAY_W'(131071), VAL_MAX, 16'd1);
        send_word(KIND_UPDATE, 9'd0, 8'd1, 24'sd5);
        send_word(KIND_UPDATE, 9'd0, 8'd1, -24'sd3);
        send_word(KIND_DECIDE, 9'd2, 8'd0, '0);
        settle_block();
        set_config('0, VAL_MIN, '0);
        send_word(KIND_UPDATE, 9'd0, 8'd1, '0);
        send_word(KIND_DECIDE, 9'd2, 8'd0, '0);
        send_word(KIND_DECIDE, 9'd1, 8'd0, '0);
        send_word(KIND_UPDATE, 9'd0, 8'd0, -24'sd1);
        send_word(KIND_DECIDE, 9'd1, 8'd0, '0);
        settle_block();
    endtask

    // random words over several register settings and idling modes
    task automatic test_random_mix();
        t_kind                     kind;
        logic [COUNT_W-1:0]        count;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] reward;
        int                        sent;
        for (int pass = 0; pass < 8; pass++) begin
            // register setting for this pass, extremes in passes 1 to 3
            case (pass)
                1: set_config('0, VAL_MIN, 16'd65535);
                2: set_config(DECAY_ONE, VAL_MAX, 16'd1);
                3: set_config(DECAY_W'($urandom_range(65537, 131071)),
                              VALUE_W'($urandom()), '0);
                default: set_config(DECAY_W'($urandom_range(0, 131071)),
                                    VALUE_W'($urandom_range(0, 2 ** 21) - 2 ** 20),
                                    PERIOD_W'($urandom_range(1, 40)));
            endcase
            // idling mode for this pass
            case (pass % 4)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 61; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 61; end
                default: begin send_idle_pct = 35; sink_stall_pct = 35; end
            endcase
            sent = 0;
            while (sent < WORDS_PER_PASS) begin
                kind = ($urandom_range(99) < 45) ? KIND_UPDATE : KIND_DECIDE;
                // counts mostly small, a few up to and past the table end
                case ($urandom_range(19))
                    0:       count = '0;
                    1:       count = COUNT_W'($urandom_range(256, 511));
                    2, 3:    count = COUNT_W'($urandom_range(41, 255));
                    4, 5, 6, 7, 8, 9: count = COUNT_W'($urandom_range(9, 40));
                    default: count = COUNT_W'($urandom_range(1, 8));
                endcase
                index = ($urandom_range(9) < 8) ? INDEX_W'($urandom_range(0, 31))
                                                : INDEX_W'($urandom_range(0, 255));
                // rewards: zero, extremes, tiny, near zero, anything
                case ($urandom_range(9))
                    0:       reward = '0;
                    1:       reward = $urandom_range(1) ? VAL_MAX : VAL_MIN;
                    2:       reward = VALUE_W'($urandom_range(0, 6) - 3);
                    3, 4, 5: reward = VALUE_W'($urandom_range(0, 2 ** 21) - 2 ** 20);
                    default: reward = VALUE_W'($urandom());
                endcase
                if (kind == KIND_UPDATE) begin
                    count = COUNT_W'($urandom());
                end
                send_word(kind, count, index, reward);
                if (kind == KIND_UPDATE || count != '0) begin
                    sent++;
                end
            end
            settle_block();
        end
    endtask

    // sink side ready with random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // compare each accepted decision word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_decisions.size() == 0) begin
                report_mismatch($sformatf("decision %0d with none expected",
                                          out_ch.decision));
            end else begin
                want_decision = expected_decisions.pop_front();
                if (out_ch.decision !== want_decision) begin
                    report_mismatch($sformatf("decision %0d, expected %0d",
                                              out_ch.decision, want_decision));
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // main sequence
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_DECAY;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_DECIDE;
        in_ch.option_count = '0;
        in_ch.option_index = '0;
        in_ch.reward_value = '0;
        send_idle_pct      = 0;
        sink_stall_pct     = 0;
        mismatch_count     = 0;
        decide_steps       = '0;
        decay_reg          = DECAY_RST;
        margin_reg         = MARGIN_RST;
        period_reg         = PERIOD_RST;
        for (int i = 0; i < TBL_ENTRIES; i++) begin
            value_est[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_table();
        test_register_corners();
        test_random_mix();

        if (expected_decisions.size() != 0) begin
            report_mismatch($sformatf("%0d decisions never arrived",
                                      expected_decisions.size()));
        end
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
